/* src/paff_pkg.sv */
// paff_pkg: shared types and constants of the polygon affine transform
// holds sequencer states, command codes, register indexes and fixed field widths
// no dependencies
package paff_pkg;

  localparam int COORD_W = 24;              // signed q15.8 coordinate
  localparam int COEF_W  = 16;              // q2.14 coefficient or factor
  localparam int MULK_W  = COEF_W + 1;      // coefficient with room for negation
  localparam int PROD_W  = COORD_W + MULK_W; // full product width
  localparam int SUM_W   = PROD_W + 1;
  localparam int FRAC_W  = 14;              // fraction bits dropped after a product
  localparam int ACT_W   = 2;
  localparam int VIDX_W  = 3;               // width of vertex index fields
  localparam int CFG_IDX_W = 2;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

  localparam logic signed [COEF_W-1:0] COS_RESET = 16'sd16322;
  localparam logic signed [COEF_W-1:0] SIN_RESET = 16'sd1424;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD      = 2'd0,
    ACT_TRANSLATE = 2'd1,
    ACT_SCALE     = 2'd2,
    ACT_ROTATE    = 2'd3
  } act_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_COS = 2'd0,
    CFG_ROT_SIN = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

endpackage

/* src/polygon_affine_transform.sv */
// polygon_affine_transform: top level, vertex memory with read-modify-write pipeline
// depends on paff_pkg
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  in      | in        | in_valid / in_ready  | action, vertex index, load, delta, scale, dir
//  out     | out       | out_valid / out_ready| out_index, out_x, out_y, out_last
//  cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data (rot_cos, rot_sin)
//
// when the output is not stalled a command item issues one memory read per vertex per
// cycle, then passes through the read register, multiply register and write-back
// a stalled output freezes the whole pipeline; the last result may still wait in the
// output register while the next item is taken
// synchronous reset, active low; vertex entries read as zero until first written
// (a valid bit per entry, cleared by reset)
module polygon_affine_transform #(
  parameter int VERTICES = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // command items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [paff_pkg::ACT_W-1:0]          in_action,
  input  logic [paff_pkg::VIDX_W-1:0]         in_vertex_index,
  input  logic signed [paff_pkg::COORD_W-1:0] in_load_x,
  input  logic signed [paff_pkg::COORD_W-1:0] in_load_y,
  input  logic signed [paff_pkg::COORD_W-1:0] in_delta_x,
  input  logic signed [paff_pkg::COORD_W-1:0] in_delta_y,
  input  logic [paff_pkg::COEF_W-1:0]         in_scale_factor,
  input  logic                                in_rotate_ccw,
  // result items
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [paff_pkg::VIDX_W-1:0]         out_index,
  output logic signed [paff_pkg::COORD_W-1:0] out_x,
  output logic signed [paff_pkg::COORD_W-1:0] out_y,
  output logic                                out_last,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [paff_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [paff_pkg::COEF_W-1:0]         cfg_data
);

  localparam int IW = $clog2(VERTICES);
  localparam int CW = (IW > paff_pkg::VIDX_W) ? IW : paff_pkg::VIDX_W;
  localparam int CORD = paff_pkg::COORD_W;
  localparam int PW = paff_pkg::PROD_W;
  localparam int SW = paff_pkg::SUM_W;
  localparam int KW = paff_pkg::MULK_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(VERTICES - 1);

  // rotation coefficients
  logic signed [paff_pkg::COEF_W-1:0] cos_r, sin_r;

  // command held for the whole run
  paff_pkg::act_t            act_r;
  logic [paff_pkg::VIDX_W-1:0] vidx_r;
  logic signed [CORD-1:0]    lx_r, ly_r, dx_r, dy_r;
  logic [paff_pkg::COEF_W-1:0] sf_r;
  logic                      ccw_r;

  // sequencer
  paff_pkg::state_t state_r, state_nxt;
  logic [IW-1:0]    cnt_r;
  logic             adv;        // whole pipeline moves
  logic             rd_en;      // memory read issued this cycle
  logic             run_done;   // final vertex written back
  logic             in_fire;

  // vertex memory and per-entry written flags
  logic [2*CORD-1:0] mem [VERTICES];
  logic [VERTICES-1:0] val_r;

  // read stage
  logic              v1_r, l1_r, ok1_r;
  logic [IW-1:0]     i1_r;
  logic [2*CORD-1:0] mem_q_r;

  // product stage
  logic              v2_r, l2_r, rnd2_r;
  logic [IW-1:0]     i2_r;
  logic signed [PW-1:0] px0_r, px1_r, py0_r, py1_r;
  logic signed [PW-1:0] px0_nxt, px1_nxt, py0_nxt, py1_nxt;
  logic              rnd_nxt;

  // output register
  logic              ov_r, ol_r;
  logic [IW-1:0]     oi_r;
  logic signed [CORD-1:0] ox_r, oy_r;

  logic signed [CORD-1:0] new_x, new_y;

  assign in_fire   = in_valid && in_ready;
  assign adv       = !ov_r || out_ready;
  assign run_done  = adv && v2_r && l2_r;
  assign cfg_ready = 1'b1;

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r <= paff_pkg::COS_RESET;
      sin_r <= paff_pkg::SIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        paff_pkg::CFG_ROT_COS: cos_r <= $signed(cfg_data);
        paff_pkg::CFG_ROT_SIN: sin_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r  <= paff_pkg::act_t'(in_action);
      vidx_r <= in_vertex_index;
      lx_r   <= in_load_x;
      ly_r   <= in_load_y;
      dx_r   <= in_delta_x;
      dy_r   <= in_delta_y;
      sf_r   <= in_scale_factor;
      ccw_r  <= in_rotate_ccw;
    end
  end

  // next state: idle, issue one read per vertex, drain until last write-back
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      paff_pkg::ST_IDLE:  if (in_fire) state_nxt = paff_pkg::ST_ISSUE;
      paff_pkg::ST_ISSUE: if (adv && cnt_r == LAST_IDX) state_nxt = paff_pkg::ST_DRAIN;
      paff_pkg::ST_DRAIN: if (run_done) state_nxt = paff_pkg::ST_IDLE;
      default:            state_nxt = paff_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    unique case (state_r)
      paff_pkg::ST_IDLE:  in_ready = 1'b1;
      paff_pkg::ST_ISSUE: rd_en    = adv;
      paff_pkg::ST_DRAIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= paff_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire)    cnt_r <= '0;
      else if (rd_en) cnt_r <= (cnt_r == LAST_IDX) ? '0 : cnt_r + 1'b1;
    end
  end

  // memory read port, data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= mem[cnt_r];
      i1_r    <= cnt_r;
      l1_r    <= (cnt_r == LAST_IDX);
      ok1_r   <= val_r[cnt_r];
    end
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      v1_r <= rd_en;
      v2_r <= v1_r;
      ov_r <= v2_r;
    end
  end

  // product stage: two products per coordinate, or the raw operands for load/translate
  logic signed [CORD-1:0] cur_x, cur_y;
  logic signed [KW-1:0]   k_cos, k_sin, k_sneg, k_sf, kx0, kx1, ky0, ky1;
  logic [CW-1:0]          i1_ext, vidx_ext;

  always_comb begin
    cur_x  = ok1_r ? $signed(mem_q_r[2*CORD-1:CORD]) : '0;
    cur_y  = ok1_r ? $signed(mem_q_r[CORD-1:0])      : '0;
    k_cos  = KW'(cos_r);
    k_sin  = ccw_r ? KW'(sin_r) : -KW'(sin_r);
    k_sneg = -k_sin;
    k_sf   = $signed({1'b0, sf_r});
    i1_ext   = CW'(i1_r);
    vidx_ext = CW'(vidx_r);
    if (act_r == paff_pkg::ACT_SCALE) begin
      kx0 = k_sf;  kx1 = '0;
      ky0 = '0;    ky1 = k_sf;
    end else begin
      kx0 = k_cos; kx1 = k_sneg;
      ky0 = k_sin; ky1 = k_cos;
    end
    px0_nxt = cur_x * kx0;
    px1_nxt = cur_y * kx1;
    py0_nxt = cur_x * ky0;
    py1_nxt = cur_y * ky1;
    rnd_nxt = 1'b1;
    case (act_r)
      paff_pkg::ACT_LOAD: begin
        rnd_nxt = 1'b0;
        px0_nxt = (i1_ext == vidx_ext) ? PW'(lx_r) : PW'(cur_x);
        py0_nxt = (i1_ext == vidx_ext) ? PW'(ly_r) : PW'(cur_y);
        px1_nxt = '0;
        py1_nxt = '0;
      end
      paff_pkg::ACT_TRANSLATE: begin
        rnd_nxt = 1'b0;
        px0_nxt = PW'(cur_x);
        px1_nxt = PW'(dx_r);
        py0_nxt = PW'(cur_y);
        py1_nxt = PW'(dy_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px0_r  <= px0_nxt;
      px1_r  <= px1_nxt;
      py0_r  <= py0_nxt;
      py1_r  <= py1_nxt;
      rnd2_r <= rnd_nxt;
      i2_r   <= i1_r;
      l2_r   <= l1_r;
    end
  end

  // sum, round half up by dropping fraction bits when rnd is set, saturate
  function automatic logic signed [CORD-1:0] fold(input logic signed [PW-1:0] a,
                                                  input logic signed [PW-1:0] b,
                                                  input logic rnd);
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] t;
    s = SW'(a) + SW'(b);
    if (rnd) t = (s + SW'(1 << (paff_pkg::FRAC_W - 1))) >>> paff_pkg::FRAC_W;
    else     t = s;
    if (t > SW'(paff_pkg::COORD_MAX))      fold = paff_pkg::COORD_MAX;
    else if (t < SW'(paff_pkg::COORD_MIN)) fold = paff_pkg::COORD_MIN;
    else                                   fold = t[CORD-1:0];
  endfunction

  assign new_x = fold(px0_r, px1_r, rnd2_r);
  assign new_y = fold(py0_r, py1_r, rnd2_r);

  // write-back; a run touches each entry once and runs never overlap
  always_ff @(posedge clk) begin
    if (adv && v2_r) begin
      mem[i2_r] <= {new_x, new_y};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (adv && v2_r) begin
      val_r[i2_r] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      ox_r <= new_x;
      oy_r <= new_y;
      oi_r <= i2_r;
      ol_r <= l2_r;
    end
  end

  logic [CW-1:0] oi_ext;
  assign oi_ext    = CW'(oi_r);
  assign out_valid = ov_r;
  assign out_index = oi_ext[paff_pkg::VIDX_W-1:0];
  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign out_last  = ol_r;

endmodule

/* src/paff_checker.sv */
// paff_checker: port-level assertions for polygon_affine_transform
// depends on paff_pkg; bound to the top level at the end of this file
module paff_checker #(
  parameter int VERTICES = 5
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [paff_pkg::VIDX_W-1:0]         out_index,
  input logic signed [paff_pkg::COORD_W-1:0] out_x,
  input logic signed [paff_pkg::COORD_W-1:0] out_y,
  input logic                                out_last
);

  localparam logic [paff_pkg::VIDX_W-1:0] LAST_OUT = paff_pkg::VIDX_W'(VERTICES - 1);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_index) && $stable(out_last))
    else $error("result changed while stalled");

  // one command at a time
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while a run is in flight");

  // the final result of a run carries the final slot
  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_index == LAST_OUT)
    else $error("last flag on wrong slot");

  // while idle only the closing result of the previous run can be pending
  a_idle_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_last)
    else $error("idle with a run still unfinished");

  // results follow slot order
  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> !out_valid
      || out_index == $past(out_index) + 3'd1)
    else $error("results out of slot order");

endmodule

bind polygon_affine_transform paff_checker #(.VERTICES(VERTICES)) u_paff_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_index (out_index),
  .out_x     (out_x),
  .out_y     (out_y),
  .out_last  (out_last)
);

/* test/tb_polygon_affine_transform.sv */
// tb_polygon_affine_transform: self-checking bench for the polygon affine transform
// table of directed commands, then phases of random commands under new rotation settings
// depends on paff_pkg and polygon_affine_transform
module tb_polygon_affine_transform;
  import paff_pkg::*;

  localparam int NUM_VERTICES  = 5;
  localparam int PIPE_LAT      = NUM_VERTICES + 5;  // drain margin after the last result
  localparam int RUN_LIMIT     = 3_000_000;
  localparam int DIRECTED_ROWS = 25;
  localparam int NUM_PHASES    = 6;
  localparam int PHASE_ITEMS   = 53;
  localparam int REPORT_MAX    = 10;

  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  // one command item as driven, plus an optional hand-worked outcome:
  // when uniform is set every vertex must come back as (ux, uy)
  typedef struct packed {
    act_t                      action;
    logic [VIDX_W-1:0]         vidx;
    logic signed [COORD_W-1:0] lx;
    logic signed [COORD_W-1:0] ly;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
    logic [COEF_W-1:0]         sf;
    logic                      ccw;
    logic                      uniform;
    logic signed [COORD_W-1:0] ux;
    logic signed [COORD_W-1:0] uy;
  } cmd_row_t;

  typedef struct packed {
    logic [VIDX_W-1:0]         idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
  } vertex_res_t;

  // receiver behaviour, re-chosen at random by the receiver process
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_SPARSE,
    RX_PERIODIC,
    RX_CHOPPY
  } rx_mode_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid        = 1'b0;
  logic                      in_ready;
  logic [ACT_W-1:0]          in_action       = '0;
  logic [VIDX_W-1:0]         in_vertex_index = '0;
  logic signed [COORD_W-1:0] in_load_x       = '0;
  logic signed [COORD_W-1:0] in_load_y       = '0;
  logic signed [COORD_W-1:0] in_delta_x      = '0;
  logic signed [COORD_W-1:0] in_delta_y      = '0;
  logic [COEF_W-1:0]         in_scale_factor = '0;
  logic                      in_rotate_ccw   = 1'b0;

  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [VIDX_W-1:0]         out_index;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic                      out_last;

  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [COEF_W-1:0]         cfg_data  = '0;

  // predicted polygon and rotation registers
  logic signed [COORD_W-1:0] poly_x [NUM_VERTICES];
  logic signed [COORD_W-1:0] poly_y [NUM_VERTICES];
  logic signed [COEF_W-1:0]  rot_cos_q;
  logic signed [COEF_W-1:0]  rot_sin_q;

  cmd_row_t    sent_rows[$];           // items driven, in the order they will be taken
  vertex_res_t vertex_results_due[$];  // vertices still to come back

  int       burst_left = 0;
  int       failures   = 0;
  int       results_seen = 0;
  int       cfg_writes = 0;
  int       act_count [4] = '{0, 0, 0, 0};
  rx_mode_t rx_mode = RX_OPEN;
  logic [7:0] rx_cyc = '0;

  polygon_affine_transform #(
    .VERTICES(NUM_VERTICES)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_vertex_index(in_vertex_index),
    .in_load_x      (in_load_x),
    .in_load_y      (in_load_y),
    .in_delta_x     (in_delta_x),
    .in_delta_y     (in_delta_y),
    .in_scale_factor(in_scale_factor),
    .in_rotate_ccw  (in_rotate_ccw),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_index      (out_index),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // directed commands; the first fifteen keep the polygon uniform so the outcome
  // can be worked by hand, the rest go through the predictor
  cmd_row_t directed_rows [DIRECTED_ROWS] = '{
    // rotate and full-scale on the all-zero polygon after reset
    '{ACT_ROTATE, 3'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'h0000, 1'b1,
      1'b1, 24'sd0, 24'sd0},
    '{ACT_SCALE, 3'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'hFFFF, 1'b0,
      1'b1, 24'sd0, 24'sd0},
    // translation to the extremes, then saturation on both sides
    '{ACT_TRANSLATE, 3'd0, 24'sd0, 24'sd0, COORD_MAX, COORD_MIN, 16'h0000, 1'b0,
      1'b1, COORD_MAX, COORD_MIN},
    '{ACT_TRANSLATE, 3'd0, 24'sd0, 24'sd0, COORD_MAX, COORD_MIN, 16'h0000, 1'b0,
      1'b1, COORD_MAX, COORD_MIN},
    '{ACT_TRANSLATE, 3'd0, 24'sd0, 24'sd0, COORD_MIN, COORD_MAX, 16'h0000, 1'b0,
      1'b1, -24'sd1, -24'sd1},
    '{ACT_TRANSLATE, 3'd0, 24'sd0, 24'sd0, COORD_MIN, COORD_MIN, 16'h0000, 1'b0,
      1'b1, COORD_MIN, COORD_MIN},
    // scale by zero clears everything
    '{ACT_SCALE, 3'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'h0000, 1'b0,
      1'b1, 24'sd0, 24'sd0},
    // unit, double and half scale on (1.0, -1.0)
    '{ACT_TRANSLATE, 3'd0, 24'sd0, 24'sd0, 24'sd256, -24'sd256, 16'h0000, 1'b0,
      1'b1, 24'sd256, -24'sd256},
    '{ACT_SCALE, 3'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'h4000, 1'b0,
      1'b1, 24'sd256, -24'sd256},
    '{ACT_SCALE, 3'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'h8000, 1'b0,
      1'b1, 24'sd512, -24'sd512},
    '{ACT_SCALE, 3'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'h2000, 1'b0,
      1'b1, 24'sd256, -24'sd256},
    // exact halves: +0.5 rounds up to 1, -0.5 rounds up to 0
    '{ACT_TRANSLATE, 3'd0, 24'sd0, 24'sd0, -24'sd255, 24'sd257, 16'h0000, 1'b0,
      1'b1, 24'sd1, 24'sd1},
    '{ACT_SCALE, 3'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'h2000, 1'b0,
      1'b1, 24'sd1, 24'sd1},
    '{ACT_TRANSLATE, 3'd0, 24'sd0, 24'sd0, -24'sd2, -24'sd2, 16'h0000, 1'b0,
      1'b1, -24'sd1, -24'sd1},
    '{ACT_SCALE, 3'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'h2000, 1'b0,
      1'b1, 24'sd0, 24'sd0},
    // loads at the corners of the polygon, with noise in the unused fields
    '{ACT_LOAD, 3'd0, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, 16'hFFFF, 1'b1,
      1'b0, 24'sd0, 24'sd0},
    '{ACT_LOAD, 3'd4, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, 16'h0000, 1'b0,
      1'b0, 24'sd0, 24'sd0},
    // loads past the end of the polygon write nothing; then a load into slot 2
    '{ACT_LOAD, 3'd5, 24'sd123, 24'sd456, 24'sd0, 24'sd0, 16'h0000, 1'b0,
      1'b0, 24'sd0, 24'sd0},
    '{ACT_LOAD, 3'd7, -24'sd77, 24'sd99, 24'sd5, 24'sd5, 16'h1234, 1'b1,
      1'b0, 24'sd0, 24'sd0},
    '{ACT_LOAD, 3'd2, 24'sh123456, -24'sh0ABCDE, 24'sd0, 24'sd0, 16'h0000, 1'b0,
      1'b0, 24'sd0, 24'sd0},
    // both directions of rotation at the reset angle, saturating at the corners
    '{ACT_ROTATE, 3'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'h0000, 1'b1,
      1'b0, 24'sd0, 24'sd0},
    '{ACT_ROTATE, 3'd6, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 16'hFFFF, 1'b0,
      1'b0, 24'sd0, 24'sd0},
    '{ACT_SCALE, 3'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'hFFFF, 1'b0,
      1'b0, 24'sd0, 24'sd0},
    '{ACT_LOAD, 3'd1, -24'sd1, 24'sd1, -24'sd1, -24'sd1, 16'hFFFF, 1'b1,
      1'b0, 24'sd0, 24'sd0},
    '{ACT_TRANSLATE, 3'd3, COORD_MIN, COORD_MAX, -24'sd300, 24'sd300, 16'hFFFF, 1'b1,
      1'b0, 24'sd0, 24'sd0}
  };

  function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
    if (v > longint'(COORD_MAX)) return COORD_MAX;
    if (v < longint'(COORD_MIN)) return COORD_MIN;
    return v[COORD_W-1:0];
  endfunction

  // drop the 14 fraction bits, half rounded towards plus infinity
  function automatic longint drop_frac(input longint v);
    return (v + 64'sd8192) >>> FRAC_W;
  endfunction

  // one affine step over every stored vertex
  task automatic transform_polygon(input cmd_row_t c);
    longint xo, yo, dxl, dyl, sfl, cl, sl;
    dxl = $signed(c.dx);
    dyl = $signed(c.dy);
    sfl = c.sf;
    cl  = rot_cos_q;
    sl  = rot_sin_q;
    if (!c.ccw) sl = -sl;
    for (int i = 0; i < NUM_VERTICES; i++) begin
      xo = poly_x[i];
      yo = poly_y[i];
      case (c.action)
        ACT_LOAD: begin
          if (c.vidx == i) begin
            poly_x[i] = c.lx;
            poly_y[i] = c.ly;
          end
        end
        ACT_TRANSLATE: begin
          poly_x[i] = clamp_coord(xo + dxl);
          poly_y[i] = clamp_coord(yo + dyl);
        end
        ACT_SCALE: begin
          poly_x[i] = clamp_coord(drop_frac(xo * sfl));
          poly_y[i] = clamp_coord(drop_frac(yo * sfl));
        end
        default: begin
          poly_x[i] = clamp_coord(drop_frac(xo * cl - yo * sl));
          poly_y[i] = clamp_coord(drop_frac(xo * sl + yo * cl));
        end
      endcase
    end
  endtask

  task automatic note_failure(input string msg);
    if (failures < REPORT_MAX) $display("%0t: %s", $realtime, msg);
    failures++;
  endtask

  // bookkeeping on the pre-edge values of both channels and the register port
  always @(posedge clk) begin : monitor
    cmd_row_t    cmd;
    cmd_row_t    row;
    vertex_res_t got;
    vertex_res_t want;
    if (!rst_n) begin
      rot_cos_q = COS_RESET;
      rot_sin_q = SIN_RESET;
      for (int i = 0; i < NUM_VERTICES; i++) begin
        poly_x[i] = '0;
        poly_y[i] = '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        case (cfg_index)
          CFG_ROT_COS: rot_cos_q = cfg_data;
          CFG_ROT_SIN: rot_sin_q = cfg_data;
          default: ;  // spare indexes leave the registers alone
        endcase
      end

      if (in_valid && in_ready) begin
        cmd = '0;
        cmd.action = act_t'(in_action);
        cmd.vidx   = in_vertex_index;
        cmd.lx     = in_load_x;
        cmd.ly     = in_load_y;
        cmd.dx     = in_delta_x;
        cmd.dy     = in_delta_y;
        cmd.sf     = in_scale_factor;
        cmd.ccw    = in_rotate_ccw;
        transform_polygon(cmd);
        act_count[in_action]++;
        row = '0;
        if (sent_rows.size() != 0) row = sent_rows.pop_front();
        for (int i = 0; i < NUM_VERTICES; i++) begin
          want.idx  = i[VIDX_W-1:0];
          want.x    = row.uniform ? row.ux : poly_x[i];
          want.y    = row.uniform ? row.uy : poly_y[i];
          want.last = (i == NUM_VERTICES - 1);
          vertex_results_due.push_back(want);
        end
      end

      if (out_valid && out_ready) begin
        results_seen++;
        got.idx  = out_index;
        got.x    = out_x;
        got.y    = out_y;
        got.last = out_last;
        if (vertex_results_due.size() == 0) begin
          note_failure($sformatf("vertex %0d (%0d, %0d) came with nothing due",
                                 got.idx, $signed(got.x), $signed(got.y)));
        end else begin
          want = vertex_results_due.pop_front();
          if (got !== want)
            note_failure($sformatf(
              "vertex mismatch: want %0d (%0d, %0d) last %0b, got %0d (%0d, %0d) last %0b",
              want.idx, $signed(want.x), $signed(want.y), want.last,
              got.idx, $signed(got.x), $signed(got.y), got.last));
        end
      end
    end
  end

  // receiver: open, sparse, periodic or choppy back-pressure, re-chosen at random
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 8'd1;
    if (rx_cyc[5:0] == 6'd0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:     out_ready <= 1'b1;
      RX_SPARSE:   out_ready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: out_ready <= (rx_cyc[3:0] < 4'd11);
      default:     out_ready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  // sender: bursts of random length, random gaps in between;
  // called right after the previous item was taken, so valid stays up unless a gap starts
  task automatic push_command(input cmd_row_t r);
    int gap;
    gap = 0;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sent_rows.push_back(r);
    in_valid        <= 1'b1;
    in_action       <= r.action;
    in_vertex_index <= r.vidx;
    in_load_x       <= r.lx;
    in_load_y       <= r.ly;
    in_delta_x      <= r.dx;
    in_delta_y      <= r.dy;
    in_scale_factor <= r.sf;
    in_rotate_ccw   <= r.ccw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  // hold the sender off until every vertex due has come back, then let the pipe settle
  task automatic idle_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (vertex_results_due.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data,
                           input bit hold);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (!hold) cfg_valid <= 1'b0;
  endtask

  // coordinates mostly small or mid-sized so rotations and scales stay interesting,
  // with full-range values and values hugging the limits mixed in
  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0, 1:    return COORD_W'($urandom_range(0, 8191) - 4096);
      2, 3:    return COORD_W'($urandom_range(0, 2097152) - 1048576);
      4:       return COORD_W'($urandom());
      5:       return COORD_W'(COORD_MAX - $urandom_range(0, 3));
      6:       return COORD_W'(COORD_MIN + $urandom_range(0, 3));
      default: return COORD_W'($urandom_range(0, 255) - 128);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_scale();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return COEF_W'(16'hFFFF - $urandom_range(0, 3));
      2, 3:    return COEF_W'($urandom());
      default: return COEF_W'($urandom_range(16'h3800, 16'h4800));  // near unity
    endcase
  endfunction

  // a command of the given kind; fields it does not use carry random noise
  function automatic cmd_row_t random_command(input act_t a);
    cmd_row_t r;
    r         = '0;
    r.action  = a;
    r.vidx    = VIDX_W'($urandom_range(0, 7));
    r.lx      = pick_coord();
    r.ly      = pick_coord();
    r.dx      = ($urandom_range(0, 1) != 0) ? pick_coord()
                                            : COORD_W'($urandom_range(0, 2047) - 1024);
    r.dy      = ($urandom_range(0, 1) != 0) ? pick_coord()
                                            : COORD_W'($urandom_range(0, 2047) - 1024);
    r.sf      = pick_scale();
    r.ccw     = ($urandom_range(0, 1) != 0);
    return r;
  endfunction

  // mostly: reload some or all vertices, then a short run of transforms;
  // the rest is fully random noise items
  task automatic run_random_phase(input int count);
    int       sent, base, nload, ops;
    cmd_row_t r;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 29) == 0) idle_until_drained();
      if ($urandom_range(0, 5) == 0) begin
        r        = '0;
        r.action = act_t'($urandom_range(0, 3));
        r.vidx   = VIDX_W'($urandom());
        r.lx     = COORD_W'($urandom());
        r.ly     = COORD_W'($urandom());
        r.dx     = COORD_W'($urandom());
        r.dy     = COORD_W'($urandom());
        r.sf     = COEF_W'($urandom());
        r.ccw    = 1'($urandom());
        push_command(r);
        sent++;
      end else begin
        base  = $urandom_range(0, NUM_VERTICES - 1);
        nload = ($urandom_range(0, 2) != 0) ? NUM_VERTICES : $urandom_range(1, NUM_VERTICES);
        for (int k = 0; k < nload; k++) begin
          r      = random_command(ACT_LOAD);
          r.vidx = VIDX_W'((base + k) % NUM_VERTICES);
          push_command(r);
          sent++;
        end
        // a stray load past the last slot now and then
        if ($urandom_range(0, 4) == 0) begin
          r      = random_command(ACT_LOAD);
          r.vidx = VIDX_W'($urandom_range(NUM_VERTICES, 7));
          push_command(r);
          sent++;
        end
        ops = $urandom_range(2, 8);
        for (int k = 0; k < ops; k++) begin
          push_command(random_command(act_t'($urandom_range(1, 3))));
          sent++;
        end
      end
    end
  endtask

  initial begin
    logic signed [COEF_W-1:0] cos_val, sin_val;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part runs at the reset rotation step
    for (int n = 0; n < DIRECTED_ROWS; n++) push_command(directed_rows[n]);

    // each random phase starts from a drained pipe with a fresh rotation setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      idle_until_drained();
      case (ph)
        0: begin cos_val = 16'sd16384;  sin_val = 16'sd0;      end  // identity
        1: begin cos_val = -16'sd16384; sin_val = 16'sd16384;  end  // both limits
        2: begin cos_val = COS_RESET;   sin_val = SIN_RESET;   end
        3: begin cos_val = 16'sh8000;   sin_val = 16'sh7FFF;   end  // outside stated range
        4: begin
          cos_val = COEF_W'($urandom_range(0, 32768) - 16384);
          sin_val = COEF_W'($urandom_range(0, 32768) - 16384);
        end
        default: begin cos_val = 16'sd0; sin_val = -16'sd16384; end  // quarter turn
      endcase
      cfg_write(CFG_ROT_COS, cos_val, 1'b1);
      // a write to a spare index must not disturb either register
      cfg_write(ph[0] ? CFG_SPARE_3 : CFG_SPARE_2, COEF_W'($urandom()), 1'b1);
      cfg_write(CFG_ROT_SIN, sin_val, 1'b0);
      run_random_phase(PHASE_ITEMS);
    end

    idle_until_drained();
    $display("covered %0d loads, %0d translates, %0d scales, %0d rotates",
             act_count[ACT_LOAD], act_count[ACT_TRANSLATE], act_count[ACT_SCALE],
             act_count[ACT_ROTATE]);
    $display("%0d vertex results checked, %0d register writes, %0d failures",
             results_seen, cfg_writes, failures);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog against a hung handshake
  initial begin
    #(RUN_LIMIT);
    $display("timeout with %0d vertex results still due", vertex_results_due.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* files.f */
src/paff_pkg.sv
src/polygon_affine_transform.sv
src/paff_checker.sv
test/tb_polygon_affine_transform.sv
